/* rtl/rlbc_pkg.sv */
`default_nettype none
package rlbc_pkg;

    localparam int unsigned CAPACITY_DEF = 1024;
    localparam int unsigned SLICES_DEF   = 65536;
    localparam int unsigned REF_BITS_DEF = 16;

    localparam int unsigned IDX_W      = 16;
    localparam int unsigned SLOT_W     = 10;
    localparam int unsigned SEC_W      = 48;
    localparam int unsigned STAT_W     = 3;
    localparam int unsigned CFG_W      = 32;
    localparam int unsigned ADDR_W     = 3;
    localparam int unsigned IN_DATA_W  = 24;
    localparam int unsigned OUT_DATA_W = 136;

    typedef enum logic [STAT_W-1:0] {
        ST_HIT      = 3'd0,
        ST_FILL     = 3'd1,
        ST_RETRY    = 3'd2,
        ST_PUT_DONE = 3'd3,
        ST_PUT_ERR  = 3'd4
    } t_status;

    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

    localparam logic REG_HEADER = 1'b0;
    localparam logic REG_SLICE  = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [IDX_W-1:0] idx;
        logic             wr;
        logic             oor;
    } t_item;

    typedef struct packed {
        logic [CFG_W-1:0] header;
        logic [CFG_W-1:0] slice;
    } t_cfg;

endpackage
`default_nettype wire

/* rtl/refcounted_lru_block_cache.sv */
// Reference-counted LRU directory for cached per-slice metadata blocks. Items are
// queued by a front stage and executed one at a time by a sequencer over slot
// memories with one write and one read port each and registered reads. A hit bumps
// the reference count, a fill links a new entry at the MRU end, a put moves its
// entry there and, when the cache is full, walks from the LRU end to evict the
// first unreferenced entry. After reset a clearing pass sweeps the slice map; no
// item is accepted during it, configuration writes are taken as usual.
`default_nettype none
module refcounted_lru_block_cache #(
    parameter int unsigned CAPACITY = rlbc_pkg::CAPACITY_DEF,
    parameter int unsigned SLICES   = rlbc_pkg::SLICES_DEF,
    parameter int unsigned REF_BITS = rlbc_pkg::REF_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // slice_index, is_write
    input  wire logic [rlbc_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // kind
    input  wire logic                            i_s_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // slot, fill_request, fill_sector, evicted, evicted_index, evicted_slot,
    // writeback_request, writeback_sector
    output logic [rlbc_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata,
    // status
    output logic [rlbc_pkg::STAT_W-1:0]          o_m_axis_tuser,
    input  wire logic                            i_psel,
    input  wire logic                            i_penable,
    input  wire logic                            i_pwrite,
    input  wire logic [rlbc_pkg::ADDR_W-1:0]     i_paddr,
    input  wire logic [rlbc_pkg::CFG_W-1:0]      i_pwdata,
    output logic [rlbc_pkg::CFG_W-1:0]           o_prdata,
    output logic                                 o_pready
);

    rlbc_pkg::t_cfg  r_cfg;
    rlbc_pkg::t_item item;
    logic            item_valid;
    logic            pop;
    logic            hold;

    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr[2] == rlbc_pkg::REG_SLICE) ? r_cfg.slice : r_cfg.header;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header <= '0;
            r_cfg.slice  <= rlbc_pkg::CFG_W'(1);
        end else if (i_psel && i_penable && i_pwrite) begin
            if (i_paddr[2] == rlbc_pkg::REG_SLICE) begin
                r_cfg.slice <= i_pwdata;
            end else begin
                r_cfg.header <= i_pwdata;
            end
        end
    end

    rlbc_front #(
        .SLICES(SLICES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_s_tdata  (i_s_axis_tdata),
        .i_s_tuser  (i_s_axis_tuser),
        .i_hold     (hold),
        .o_item     (item),
        .o_valid    (item_valid),
        .i_pop      (pop)
    );

    rlbc_back #(
        .CAPACITY (CAPACITY),
        .SLICES   (SLICES),
        .REF_BITS (REF_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_item     (item),
        .i_valid    (item_valid),
        .o_pop      (pop),
        .o_hold     (hold),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_m_tdata  (o_m_axis_tdata),
        .o_m_tuser  (o_m_axis_tuser)
    );

endmodule
`default_nettype wire

/* rtl/rlbc_front.sv */
`default_nettype none
module rlbc_front #(
    parameter int unsigned SLICES = rlbc_pkg::SLICES_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    input  wire logic [rlbc_pkg::IN_DATA_W-1:0] i_s_tdata,
    input  wire logic                           i_s_tuser,
    input  wire logic                           i_hold,
    output rlbc_pkg::t_item                     o_item,
    output logic                                o_valid,
    input  wire logic                           i_pop
);

    rlbc_pkg::t_item r_q [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    rlbc_pkg::t_item in_item;
    logic            push;

    always_comb begin
        in_item.kind = i_s_tuser;
        in_item.idx  = i_s_tdata[rlbc_pkg::IDX_W-1:0];
        in_item.wr   = i_s_tdata[rlbc_pkg::IDX_W];
        in_item.oor  = (32'(i_s_tdata[rlbc_pkg::IDX_W-1:0]) >= 32'(SLICES));
    end

    assign o_s_tready = (r_cnt != 2'd2) && !i_hold;
    assign push       = i_s_tvalid && o_s_tready;
    assign o_valid    = (r_cnt != 2'd0);
    assign o_item     = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= in_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop && o_valid) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop && o_valid);
        end
    end

endmodule
`default_nettype wire

/* rtl/rlbc_back.sv */
`default_nettype none
module rlbc_back #(
    parameter int unsigned CAPACITY = rlbc_pkg::CAPACITY_DEF,
    parameter int unsigned SLICES   = rlbc_pkg::SLICES_DEF,
    parameter int unsigned REF_BITS = rlbc_pkg::REF_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire rlbc_pkg::t_cfg                  i_cfg,
    input  wire rlbc_pkg::t_item                 i_item,
    input  wire logic                            i_valid,
    output logic                                 o_pop,
    output logic                                 o_hold,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic [rlbc_pkg::OUT_DATA_W-1:0]      o_m_tdata,
    output logic [rlbc_pkg::STAT_W-1:0]          o_m_tuser
);

    localparam int unsigned SW = $clog2(CAPACITY);
    localparam int unsigned LW = $clog2(CAPACITY + 1);
    localparam int unsigned CW = LW;
    localparam int unsigned MW = $clog2(SLICES);
    localparam int unsigned IW = rlbc_pkg::IDX_W;
    localparam int unsigned XW = rlbc_pkg::SEC_W;
    localparam logic [LW-1:0] NONE = LW'(CAPACITY);
    localparam logic [CW-1:0] FULL = CW'(CAPACITY);
    localparam logic [REF_BITS-1:0] REF_MAX = '1;
    localparam logic [MW-1:0] MAP_LAST = MW'(SLICES - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_MAPW, S_HIT, S_FILL, S_FILL2, S_PREF, S_MV1, S_MV2, S_MV3,
        S_EVCHK, S_WALK, S_WALKW, S_EV1, S_EV2, S_RES
    } t_state;

    logic [SW:0]          r_map   [SLICES];
    logic [IW-1:0]        r_owner [CAPACITY];
    logic [REF_BITS-1:0]  r_ref   [CAPACITY];
    logic                 r_dirty [CAPACITY];
    logic [LW-1:0]        r_prev  [CAPACITY];
    logic [LW-1:0]        r_next  [CAPACITY];
    logic [SW-1:0]        r_free  [CAPACITY];

    logic [SW:0]          r_map_rd;
    logic [IW-1:0]        r_owner_rd;
    logic [REF_BITS-1:0]  r_ref_rd;
    logic                 r_dirty_rd;
    logic [LW-1:0]        r_prev_rd;
    logic [LW-1:0]        r_next_rd;
    logic [SW-1:0]        r_free_rd;

    logic                 map_we;
    logic [MW-1:0]        map_wa, map_ra;
    logic [SW:0]          map_wd;
    logic                 owner_we;
    logic [SW-1:0]        owner_wa, owner_ra;
    logic [IW-1:0]        owner_wd;
    logic                 ref_we;
    logic [SW-1:0]        ref_wa, ref_ra;
    logic [REF_BITS-1:0]  ref_wd;
    logic                 dirty_we;
    logic [SW-1:0]        dirty_wa, dirty_ra;
    logic                 dirty_wd;
    logic                 prev_we;
    logic [SW-1:0]        prev_wa, prev_ra;
    logic [LW-1:0]        prev_wd;
    logic                 next_we;
    logic [SW-1:0]        next_wa, next_ra;
    logic [LW-1:0]        next_wd;
    logic                 free_we;
    logic [SW-1:0]        free_wa, free_ra;
    logic [SW-1:0]        free_wd;

    t_state               r_state, n_state;
    logic                 r_clr, n_clr;
    logic [MW-1:0]        r_clr_addr, n_clr_addr;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_hwm, n_hwm;
    logic [LW-1:0]        r_head, n_head;
    logic [LW-1:0]        r_tail, n_tail;
    rlbc_pkg::t_item      r_item, n_item;
    logic [SW-1:0]        r_s, n_s;
    logic [LW-1:0]        r_p, n_p;
    logic [LW-1:0]        r_n, n_n;
    logic [LW-1:0]        r_cur, n_cur;
    logic [LW-1:0]        r_pc, n_pc;
    logic [XW-1:0]        r_prod, n_prod;
    logic                 r_frpos, n_frpos;
    rlbc_pkg::t_status    r_status, n_status;
    logic [rlbc_pkg::SLOT_W-1:0] r_slot, n_slot;
    logic                 r_fill, n_fill;
    logic [XW-1:0]        r_fsec, n_fsec;
    logic                 r_ev, n_ev;
    logic [IW-1:0]        r_evidx, n_evidx;
    logic [rlbc_pkg::SLOT_W-1:0] r_evslot, n_evslot;
    logic                 r_wb, n_wb;
    logic [XW-1:0]        r_wsec, n_wsec;
    logic                 r_ovalid, n_ovalid;
    logic [rlbc_pkg::OUT_DATA_W-1:0] r_odata, n_odata;
    logic [rlbc_pkg::STAT_W-1:0]     r_ouser, n_ouser;

    logic [CW-1:0]        count_dec;
    logic [SW-1:0]        fill_slot;

    assign count_dec = r_count - CW'(1);
    assign fill_slot = r_frpos ? r_count[SW-1:0] : r_free_rd;

    always_ff @(posedge i_clk) begin
        if (map_we) r_map[map_wa] <= map_wd;
        r_map_rd <= r_map[map_ra];
    end
    always_ff @(posedge i_clk) begin
        if (owner_we) r_owner[owner_wa] <= owner_wd;
        r_owner_rd <= r_owner[owner_ra];
    end
    always_ff @(posedge i_clk) begin
        if (ref_we) r_ref[ref_wa] <= ref_wd;
        r_ref_rd <= r_ref[ref_ra];
    end
    always_ff @(posedge i_clk) begin
        if (dirty_we) r_dirty[dirty_wa] <= dirty_wd;
        r_dirty_rd <= r_dirty[dirty_ra];
    end
    always_ff @(posedge i_clk) begin
        if (prev_we) r_prev[prev_wa] <= prev_wd;
        r_prev_rd <= r_prev[prev_ra];
    end
    always_ff @(posedge i_clk) begin
        if (next_we) r_next[next_wa] <= next_wd;
        r_next_rd <= r_next[next_ra];
    end
    always_ff @(posedge i_clk) begin
        if (free_we) r_free[free_wa] <= free_wd;
        r_free_rd <= r_free[free_ra];
    end

    always_comb begin
        n_state = r_state;  n_clr = r_clr;  n_clr_addr = r_clr_addr;
        n_count = r_count;  n_hwm = r_hwm;  n_head = r_head;  n_tail = r_tail;
        n_item = r_item;  n_s = r_s;  n_p = r_p;  n_n = r_n;  n_cur = r_cur;
        n_pc = r_pc;  n_prod = r_prod;  n_frpos = r_frpos;
        n_status = r_status;  n_slot = r_slot;  n_fill = r_fill;  n_fsec = r_fsec;
        n_ev = r_ev;  n_evidx = r_evidx;  n_evslot = r_evslot;  n_wb = r_wb;
        n_wsec = r_wsec;
        n_ovalid = r_ovalid && !i_m_tready;
        n_odata = r_odata;  n_ouser = r_ouser;
        o_pop = 1'b0;

        map_we = 1'b0;  map_wa = MW'(r_owner_rd);  map_wd = '0;
        map_ra = MW'(r_item.idx);
        owner_we = 1'b0;  owner_wa = r_s;  owner_wd = r_item.idx;
        owner_ra = r_cur[SW-1:0];
        ref_we = 1'b0;  ref_wa = r_s;  ref_wd = r_ref_rd;  ref_ra = r_cur[SW-1:0];
        dirty_we = 1'b0;  dirty_wa = r_s;  dirty_wd = 1'b0;
        dirty_ra = r_cur[SW-1:0];
        prev_we = 1'b0;  prev_wa = r_s;  prev_wd = NONE;  prev_ra = r_cur[SW-1:0];
        next_we = 1'b0;  next_wa = r_s;  next_wd = r_head;  next_ra = r_cur[SW-1:0];
        free_we = 1'b0;  free_wa = count_dec[SW-1:0];  free_wd = r_cur[SW-1:0];
        free_ra = r_count[SW-1:0];

        if (r_clr) begin
            map_we = 1'b1;
            map_wa = r_clr_addr;
            map_wd = '0;
            n_clr_addr = r_clr_addr + MW'(1);
            if (r_clr_addr == MAP_LAST) n_clr = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (!r_clr && i_valid) begin
                    o_pop = 1'b1;
                    n_item = i_item;
                    n_prod = XW'(i_item.idx) * XW'(i_cfg.slice);
                    n_status = rlbc_pkg::ST_HIT;
                    n_slot = '0;  n_fill = 1'b0;  n_fsec = '0;
                    n_ev = 1'b0;  n_evidx = '0;  n_evslot = '0;
                    n_wb = 1'b0;  n_wsec = '0;
                    if (i_item.oor) begin
                        n_status = (i_item.kind == rlbc_pkg::KIND_PUT) ?
                                   rlbc_pkg::ST_PUT_ERR : rlbc_pkg::ST_RETRY;
                        n_state = S_RES;
                    end else begin
                        map_ra = MW'(i_item.idx);
                        n_state = S_MAPW;
                    end
                end
            end
            S_MAPW: begin
                n_s = r_map_rd[SW-1:0];
                ref_ra = r_map_rd[SW-1:0];
                prev_ra = r_map_rd[SW-1:0];
                next_ra = r_map_rd[SW-1:0];
                if (r_item.kind == rlbc_pkg::KIND_GET) begin
                    if (r_map_rd[SW]) begin
                        n_state = S_HIT;
                    end else if (r_count >= FULL) begin
                        n_status = rlbc_pkg::ST_RETRY;
                        n_state = S_RES;
                    end else begin
                        free_ra = r_count[SW-1:0];
                        n_frpos = (r_count >= r_hwm);
                        n_state = S_FILL;
                    end
                end else begin
                    if (r_map_rd[SW]) begin
                        n_state = S_PREF;
                    end else begin
                        n_status = rlbc_pkg::ST_PUT_ERR;
                        n_state = S_RES;
                    end
                end
            end
            S_HIT: begin
                ref_we = 1'b1;
                ref_wd = (r_ref_rd == REF_MAX) ? r_ref_rd : r_ref_rd + REF_BITS'(1);
                if (r_item.wr) begin
                    dirty_we = 1'b1;
                    dirty_wd = 1'b1;
                end
                n_status = rlbc_pkg::ST_HIT;
                n_slot = rlbc_pkg::SLOT_W'(r_s);
                n_state = S_RES;
            end
            S_FILL: begin
                n_s = fill_slot;
                map_we = 1'b1;
                map_wa = MW'(r_item.idx);
                map_wd = {1'b1, fill_slot};
                owner_we = 1'b1;  owner_wa = fill_slot;  owner_wd = r_item.idx;
                ref_we = 1'b1;  ref_wa = fill_slot;  ref_wd = REF_BITS'(1);
                dirty_we = 1'b1;  dirty_wa = fill_slot;  dirty_wd = r_item.wr;
                prev_we = 1'b1;  prev_wa = fill_slot;  prev_wd = NONE;
                next_we = 1'b1;  next_wa = fill_slot;  next_wd = r_head;
                n_count = r_count + CW'(1);
                n_status = rlbc_pkg::ST_FILL;
                n_slot = rlbc_pkg::SLOT_W'(fill_slot);
                n_fill = 1'b1;
                n_fsec = XW'(i_cfg.header) + r_prod;
                if (r_head != NONE) begin
                    n_state = S_FILL2;
                end else begin
                    n_head = LW'(fill_slot);
                    n_tail = LW'(fill_slot);
                    n_state = S_RES;
                end
            end
            S_FILL2: begin
                prev_we = 1'b1;
                prev_wa = r_head[SW-1:0];
                prev_wd = LW'(r_s);
                n_head = LW'(r_s);
                n_state = S_RES;
            end
            S_PREF: begin
                if (r_ref_rd == '0) begin
                    n_status = rlbc_pkg::ST_PUT_ERR;
                    n_state = S_RES;
                end else begin
                    ref_we = 1'b1;
                    ref_wd = r_ref_rd - REF_BITS'(1);
                    n_p = r_prev_rd;
                    n_n = r_next_rd;
                    n_status = rlbc_pkg::ST_PUT_DONE;
                    n_slot = rlbc_pkg::SLOT_W'(r_s);
                    n_state = (r_prev_rd == NONE) ? S_EVCHK : S_MV1;
                end
            end
            S_MV1: begin
                next_we = 1'b1;
                next_wa = r_p[SW-1:0];
                next_wd = r_n;
                if (r_n != NONE) begin
                    prev_we = 1'b1;
                    prev_wa = r_n[SW-1:0];
                    prev_wd = r_p;
                end else begin
                    n_tail = r_p;
                end
                n_state = S_MV2;
            end
            S_MV2: begin
                next_we = 1'b1;  next_wa = r_s;  next_wd = r_head;
                prev_we = 1'b1;  prev_wa = r_s;  prev_wd = NONE;
                n_state = S_MV3;
            end
            S_MV3: begin
                prev_we = 1'b1;
                prev_wa = r_head[SW-1:0];
                prev_wd = LW'(r_s);
                n_head = LW'(r_s);
                n_state = S_EVCHK;
            end
            S_EVCHK: begin
                if (r_count >= FULL) begin
                    n_cur = r_tail;
                    n_state = S_WALK;
                end else begin
                    n_state = S_RES;
                end
            end
            S_WALK: begin
                n_state = (r_cur == NONE) ? S_RES : S_WALKW;
            end
            S_WALKW: begin
                if (r_ref_rd == '0) begin
                    n_pc = r_prev_rd;
                    n_state = S_EV1;
                end else begin
                    n_cur = r_prev_rd;
                    n_state = S_WALK;
                end
            end
            S_EV1: begin
                map_we = 1'b1;
                map_wa = MW'(r_owner_rd);
                map_wd = '0;
                if (r_pc != NONE) begin
                    next_we = 1'b1;
                    next_wa = r_pc[SW-1:0];
                    next_wd = r_next_rd;
                end else begin
                    n_head = r_next_rd;
                end
                if (r_next_rd != NONE) begin
                    prev_we = 1'b1;
                    prev_wa = r_next_rd[SW-1:0];
                    prev_wd = r_pc;
                end else begin
                    n_tail = r_pc;
                end
                n_count = count_dec;
                free_we = 1'b1;
                if (r_hwm < r_count) n_hwm = r_count;
                dirty_we = 1'b1;
                dirty_wa = r_cur[SW-1:0];
                dirty_wd = 1'b0;
                n_ev = 1'b1;
                n_evidx = r_owner_rd;
                n_evslot = rlbc_pkg::SLOT_W'(r_cur);
                n_wb = r_dirty_rd;
                n_prod = XW'(r_owner_rd) * XW'(i_cfg.slice);
                n_state = S_EV2;
            end
            S_EV2: begin
                if (r_wb) n_wsec = XW'(i_cfg.header) + r_prod;
                n_state = S_RES;
            end
            S_RES: begin
                if (!r_ovalid || i_m_tready) begin
                    n_ovalid = 1'b1;
                    n_ouser = r_status;
                    n_odata = {1'b0, r_wsec, r_wb, r_evslot, r_evidx, r_ev,
                               r_fsec, r_fill, r_slot};
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;  r_s <= n_s;  r_p <= n_p;  r_n <= n_n;
        r_cur <= n_cur;  r_pc <= n_pc;  r_prod <= n_prod;  r_frpos <= n_frpos;
        r_status <= n_status;  r_slot <= n_slot;  r_fill <= n_fill;
        r_fsec <= n_fsec;  r_ev <= n_ev;  r_evidx <= n_evidx;
        r_evslot <= n_evslot;  r_wb <= n_wb;  r_wsec <= n_wsec;
        r_odata <= n_odata;  r_ouser <= n_ouser;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_clr <= 1'b1;
            r_clr_addr <= '0;
            r_count <= '0;
            r_hwm <= '0;
            r_head <= NONE;
            r_tail <= NONE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr <= n_clr;
            r_clr_addr <= n_clr_addr;
            r_count <= n_count;
            r_hwm <= n_hwm;
            r_head <= n_head;
            r_tail <= n_tail;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_hold     = r_clr;
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ouser;

endmodule
`default_nettype wire

/* rtl/rlbc_checker.sv */
`default_nettype none
module rlbc_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            o_m_axis_tvalid,
    input wire logic                            i_m_axis_tready,
    input wire logic [rlbc_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input wire logic [rlbc_pkg::STAT_W-1:0]     o_m_axis_tuser
);

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result dropped under stall");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tuser <= rlbc_pkg::STAT_W'(rlbc_pkg::ST_PUT_ERR))
        else $error("bad status");

    a_fill_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[10] |->
        o_m_axis_tuser == rlbc_pkg::STAT_W'(rlbc_pkg::ST_FILL))
        else $error("fill without miss");

    a_evict_on_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[59] |->
        o_m_axis_tuser == rlbc_pkg::STAT_W'(rlbc_pkg::ST_PUT_DONE))
        else $error("eviction outside put");

    a_wb_needs_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[86] |-> o_m_axis_tdata[59])
        else $error("writeback without eviction");

endmodule

bind refcounted_lru_block_cache rlbc_checker u_rlbc_checker (.*);
`default_nettype wire

/* tb/sv/tb_top.sv */
`default_nettype none
import rlbc_pkg::*;

typedef struct {
    t_status          status;
    logic [SLOT_W-1:0] slot;
    logic             fill_req;
    logic [SEC_W-1:0] fill_sec;
    logic             evicted;
    logic [IDX_W-1:0] ev_idx;
    logic [SLOT_W-1:0] ev_slot;
    logic             wb_req;
    logic [SEC_W-1:0] wb_sec;
} cache_answer_t;

class cache_directory_sb;
    localparam int unsigned CAP  = 1024;
    localparam int unsigned NONE = CAP;
    localparam int unsigned RMAX = 65535;

    bit                present[65536];
    bit [SLOT_W-1:0]   map_slot[65536];
    bit [IDX_W-1:0]    owner[CAP];
    int unsigned       refs[CAP];
    bit                dirty[CAP];
    int unsigned       prv[CAP];
    int unsigned       nxt[CAP];
    int unsigned       free_stk[CAP];
    int unsigned       resident;
    int unsigned       head;
    int unsigned       tail;
    bit [31:0]         hdr;
    bit [31:0]         stride;
    cache_answer_t     answers_due[$];
    int                errors;

    function new();
        hdr = 0;
        stride = 1;
        for (int unsigned i = 0; i < CAP; i++) free_stk[i] = i;
        resident = 0;
        head = NONE;
        tail = NONE;
        errors = 0;
    endfunction

    function bit [SEC_W-1:0] sector_of(bit [IDX_W-1:0] idx);
        bit [63:0] full_sec;
        full_sec = 64'(hdr) + 64'(idx) * 64'(stride);
        return full_sec[SEC_W-1:0];
    endfunction

    function void unlink(int unsigned s);
        int unsigned p;
        int unsigned n;
        p = prv[s];
        n = nxt[s];
        if (p < NONE) nxt[p] = n; else head = n;
        if (n < NONE) prv[n] = p; else tail = p;
    endfunction

    function void push_mru(int unsigned s);
        prv[s] = NONE;
        nxt[s] = head;
        if (head < NONE) prv[head] = s; else tail = s;
        head = s;
    endfunction

    function void note(logic kind, logic [IDX_W-1:0] idx, logic wr);
        cache_answer_t a;
        int unsigned s;
        int unsigned cur;
        bit found;
        a = '{status: ST_HIT, default: '0};
        found = 0;
        if (kind == KIND_GET) begin
            if (present[idx]) begin
                s = map_slot[idx];
                if (refs[s] < RMAX) refs[s]++;
                if (wr) dirty[s] = 1;
                a.status = ST_HIT;
                a.slot = SLOT_W'(s);
            end else if (resident >= CAP) begin
                a.status = ST_RETRY;
            end else begin
                s = free_stk[resident];
                resident++;
                present[idx] = 1;
                map_slot[idx] = SLOT_W'(s);
                owner[s] = idx;
                refs[s] = 1;
                dirty[s] = wr;
                push_mru(s);
                a.status = ST_FILL;
                a.slot = SLOT_W'(s);
                a.fill_req = 1;
                a.fill_sec = sector_of(idx);
            end
        end else if (!present[idx] || refs[map_slot[idx]] == 0) begin
            a.status = ST_PUT_ERR;
        end else begin
            s = map_slot[idx];
            refs[s]--;
            unlink(s);
            push_mru(s);
            a.status = ST_PUT_DONE;
            a.slot = SLOT_W'(s);
            if (resident >= CAP) begin
                cur = tail;
                for (int unsigned k = 0; k < CAP && cur < NONE; k++) begin
                    if (refs[cur] == 0) begin
                        found = 1;
                        break;
                    end
                    cur = prv[cur];
                end
                if (found) begin
                    present[owner[cur]] = 0;
                    unlink(cur);
                    resident--;
                    free_stk[resident] = cur;
                    a.evicted = 1;
                    a.ev_idx = owner[cur];
                    a.ev_slot = SLOT_W'(cur);
                    if (dirty[cur]) begin
                        a.wb_req = 1;
                        a.wb_sec = sector_of(owner[cur]);
                    end
                    dirty[cur] = 0;
                end
            end
        end
        answers_due.push_back(a);
    endfunction

    function void check(logic [STAT_W-1:0] st, logic [OUT_DATA_W-1:0] d);
        cache_answer_t e;
        if (answers_due.size() == 0) begin
            $error("unexpected result transfer, status %0d", st);
            errors++;
            return;
        end
        e = answers_due.pop_front();
        if (st !== e.status) begin
            $error("status: expected %0d actual %0d", e.status, st); errors++;
        end
        if (d[9:0] !== e.slot) begin
            $error("slot: expected %0d actual %0d", e.slot, d[9:0]); errors++;
        end
        if (d[10] !== e.fill_req) begin
            $error("fill_request: expected %0d actual %0d", e.fill_req, d[10]); errors++;
        end
        if (d[58:11] !== e.fill_sec) begin
            $error("fill_sector: expected %0h actual %0h", e.fill_sec, d[58:11]); errors++;
        end
        if (d[59] !== e.evicted) begin
            $error("evicted: expected %0d actual %0d", e.evicted, d[59]); errors++;
        end
        if (d[75:60] !== e.ev_idx) begin
            $error("evicted_index: expected %0d actual %0d", e.ev_idx, d[75:60]); errors++;
        end
        if (d[85:76] !== e.ev_slot) begin
            $error("evicted_slot: expected %0d actual %0d", e.ev_slot, d[85:76]); errors++;
        end
        if (d[86] !== e.wb_req) begin
            $error("writeback_request: expected %0d actual %0d", e.wb_req, d[86]); errors++;
        end
        if (d[134:87] !== e.wb_sec) begin
            $error("writeback_sector: expected %0h actual %0h", e.wb_sec, d[134:87]);
            errors++;
        end
    endfunction
endclass

module tb_top;
    localparam int WATCHDOG_LIMIT = 300000;

    logic                  i_clk = 0;
    logic                  i_rst_n = 0;
    logic                  s_tvalid = 0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = KIND_GET;
    logic                  m_tvalid;
    logic                  m_tready = 0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STAT_W-1:0]     m_tuser;
    logic                  psel = 0;
    logic                  penable = 0;
    logic                  pwrite = 0;
    logic [ADDR_W-1:0]     paddr = '0;
    logic [CFG_W-1:0]      pwdata = '0;
    logic [CFG_W-1:0]      prdata;
    logic                  pready;

    int unsigned send_idle = 32;
    int unsigned recv_idle = 66;
    int          stall_cycles = 0;
    cache_directory_sb dir_sb = new();

    refcounted_lru_block_cache dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tuser(s_tuser),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata), .o_m_axis_tuser(m_tuser),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite),
        .i_paddr(paddr), .i_pwdata(pwdata), .o_prdata(prdata), .o_pready(pready)
    );

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    always @(posedge i_clk) begin
        if (m_tvalid && m_tready) dir_sb.check(m_tuser, m_tdata);
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic apb_write(logic reg_sel, logic [CFG_W-1:0] value);
        @(posedge i_clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {reg_sel, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        if (reg_sel == REG_HEADER) dir_sb.hdr = value; else dir_sb.stride = value;
    endtask

    task automatic send(logic kind, logic [IDX_W-1:0] idx, logic wr);
        if ($urandom_range(99) < send_idle) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_tvalid <= 1;
        s_tuser <= kind;
        s_tdata <= {7'b0, wr, idx};
        do @(posedge i_clk); while (!s_tready);
        dir_sb.note(kind, idx, wr);
    endtask

    task automatic random_ops(int n, int unsigned pool_base, int unsigned pool_span);
        logic [IDX_W-1:0] idx;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) < 8) idx = IDX_W'(pool_base + $urandom_range(pool_span - 1));
            else idx = IDX_W'($urandom);
            send(1'($urandom), idx, 1'($urandom));
        end
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (dir_sb.answers_due.size() != 0) @(posedge i_clk);
        repeat (2200) @(posedge i_clk);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        apb_write(REG_HEADER, 32'd100);
        apb_write(REG_SLICE, 32'd8);

        // directed: fill, hits, dirty mark, puts, put errors, extreme slices
        send(KIND_GET, 16'd0, 0);
        send(KIND_GET, 16'd0, 0);
        send(KIND_GET, 16'd0, 1);
        send(KIND_PUT, 16'd0, 0);
        send(KIND_PUT, 16'd0, 1);
        send(KIND_PUT, 16'd0, 0);
        send(KIND_PUT, 16'd0, 0);
        send(KIND_PUT, 16'd65535, 0);
        send(KIND_GET, 16'd65535, 1);
        send(KIND_GET, 16'hAAAA, 0);
        send(KIND_GET, 16'h5555, 1);
        send(KIND_PUT, 16'd65535, 1);
        send(KIND_PUT, 16'hAAAA, 0);
        send(KIND_PUT, 16'd12345, 0);
        random_ops(250, 0, 64);
        drain();

        send_idle = 66;
        recv_idle = 32;
        apb_write(REG_HEADER, 32'hFFFF_FFFF);
        apb_write(REG_SLICE, 32'd1);
        // a run of fresh slices, mostly dropping the references again
        for (int i = 0; i < 120; i++) begin
            send(KIND_GET, IDX_W'(2000 + i), 1'($urandom));
            if ($urandom_range(3) != 0) send(KIND_PUT, IDX_W'(2000 + i), 1'($urandom));
        end
        random_ops(100, 2000, 160);
        drain();

        send_idle = 0;
        recv_idle = 0;
        apb_write(REG_HEADER, 32'hFFFF_FFFF);
        apb_write(REG_SLICE, 32'hFFFF_FFFF);
        random_ops(90, 2000, 200);
        drain();

        if (dir_sb.errors == 0 && dir_sb.answers_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

`default_nettype wire
